>>> hw/rtl/mem_stage_direct_mapped_cache_core_assert.svh
// Assertion macros for the memory stage cache core.
`ifndef MEM_STAGE_DIRECT_MAPPED_CACHE_CORE_ASSERT_SVH
`define MEM_STAGE_DIRECT_MAPPED_CACHE_CORE_ASSERT_SVH

// A property that must hold at every clock edge outside reset.
`define MDC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition that must be followed by another in the next cycle.
`define MDC_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

>>> hw/rtl/mdc_pkg.sv
// Types and constants shared by the memory stage cache core.
`default_nettype none

package mdc_pkg;

  localparam int DATA_W      = 32;
  localparam int OPC_W       = 7;
  localparam int WAIT_W      = 8;
  localparam int CFG_IDX_W   = 1;
  localparam int LINE_WORDS  = 4;
  localparam int LINE_OFS_W  = 2;
  localparam int IN_W        = 168;
  localparam int OUT_W       = 296;

  // Memory and cache sizes are powers of two so that indexes are bit fields.
  localparam int MEM_WORDS   = 256;
  localparam int CACHE_LINES = 4;
  localparam int WORD_W      = $clog2(MEM_WORDS);
  localparam int BLOCK_W     = WORD_W - LINE_OFS_W;
  localparam int LINE_W      = $clog2(CACHE_LINES);
  localparam int CIDX_W      = LINE_W + LINE_OFS_W;

  localparam logic [OPC_W-1:0] OP_BUBBLE = 7'd1;
  localparam logic [OPC_W-1:0] OP_LW     = 7'd5;
  localparam logic [OPC_W-1:0] OP_SW     = 7'd37;
  localparam logic [OPC_W-1:0] OP_LR     = 7'd51;
  localparam logic [OPC_W-1:0] OP_SC     = 7'd52;
  localparam logic [OPC_W-1:0] OP_ALU0   = 7'd19;
  localparam logic [OPC_W-1:0] OP_ALU1   = 7'd71;
  localparam logic [OPC_W-1:0] OP_ALU2   = 7'd83;
  localparam logic [OPC_W-1:0] OP_ALU3   = 7'd72;
  localparam logic [OPC_W-1:0] OP_ALU4   = 7'd56;
  localparam logic [OPC_W-1:0] OP_ALU5   = 7'd111;
  localparam logic [OPC_W-1:0] OP_ALU6   = 7'd103;

  localparam logic [CFG_IDX_W-1:0] REG_LOAD_MISS_WAIT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STORE_WAIT     = 1'd1;

  localparam logic [WAIT_W-1:0] LOAD_MISS_WAIT_RST = 8'd47;
  localparam logic [WAIT_W-1:0] STORE_WAIT_RST     = 8'd11;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DEC,
    ST_LOOK,
    ST_FILL,
    ST_OUT
  } mdc_state_t;

  function automatic logic is_alu_op(input logic [OPC_W-1:0] op);
    return (op == OP_ALU0) || (op == OP_ALU1) || (op == OP_ALU2) || (op == OP_ALU3) ||
           (op == OP_ALU4) || (op == OP_ALU5) || (op == OP_ALU6);
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/mdc_mod_unit.sv
// Address split of a byte address into memory word, block, cache line and cache word index.
`default_nettype none

module mdc_mod_unit
  import mdc_pkg::*;
(
  input  wire logic [DATA_W-1:0]  addr,
  output logic      [WORD_W-1:0]  word,
  output logic      [BLOCK_W-1:0] block,
  output logic      [LINE_W-1:0]  line,
  output logic      [CIDX_W-1:0]  cidx
);

  assign word  = addr[WORD_W+1:2];
  assign block = word[WORD_W-1:LINE_OFS_W];
  assign line  = block[LINE_W-1:0];
  assign cidx  = {line, word[LINE_OFS_W-1:0]};

endmodule

`default_nettype wire

>>> hw/rtl/mem_stage_direct_mapped_cache_core.sv
// Memory stage with a direct-mapped write-through data cache in front of a word memory.
//
// Each request on the in_ channel yields exactly one result on the out_ channel.
// Requests are taken one at a time. A request that does not touch memory passes
// the decode and output states before the input is free again; its result is
// registered as it leaves the output state. A load or store checks the tag in its
// decode cycle; a load hit adds a lookup state for the cache word read.
// While a miss or store is pending, each request yields a bubble result until
// the wait register is reached; the completing request of a load miss refills
// the line from memory in the fill state, one memory read per cycle.
// After reset the block clears all MEM_WORDS words of the data memory, one word
// a cycle, and takes no request until then; configuration writes are
// taken at any time. A result waits in the output register while out_tready is
// low; the next request is accepted meanwhile and waits for the register.
`default_nettype none
`include "mem_stage_direct_mapped_cache_core_assert.svh"

module mem_stage_direct_mapped_cache_core
  import mdc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [WAIT_W-1:0]    cfg_wdata,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  // opcode[6:0], instr_field_a[38:7], instr_field_b[70:39], instr_field_c[102:71],
  // alu_result[134:103], store_value[166:135], zero[167]
  input  wire logic [IN_W-1:0]      in_tdata,
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  // opcode_out[6:0], field_a_out[38:7], field_b_out[70:39], field_c_out[102:71],
  // alu_out[134:103], load_word[166:135], stall_res[167], read_requests[199:168],
  // read_misses[231:200], write_requests[263:232], write_misses[295:264]
  output logic [OUT_W-1:0]          out_tdata
);

  localparam int WW     = WORD_W;
  localparam int BW     = BLOCK_W;
  localparam int LW     = LINE_W;
  localparam int CI_W   = CIDX_W;
  localparam int CDEPTH = CACHE_LINES * LINE_WORDS;
  localparam int FC_W   = LINE_OFS_W + 1;

  mdc_state_t state_r, state_nxt;

  logic [WAIT_W-1:0] lmw_r, lmw_nxt, sw_r, sw_nxt;
  logic [WW-1:0]     clr_r, clr_nxt;

  logic [OPC_W-1:0]  op_r, op_nxt;
  logic [DATA_W-1:0] fa_r, fa_nxt, fb_r, fb_nxt, fc_r, fc_nxt;
  logic [DATA_W-1:0] alu_in_r, alu_in_nxt, val_r, val_nxt;

  logic              lp_r, lp_nxt, sp_r, sp_nxt;
  logic [WAIT_W-1:0] wait_r, wait_nxt, limit;
  logic [DATA_W-1:0] paddr_r, paddr_nxt, pval_r, pval_nxt;
  logic [WW-1:0]     pword_r, pword_nxt;
  logic [LW-1:0]     pline_r, pline_nxt;
  logic [FC_W-1:0]   fill_r, fill_nxt;

  logic [DATA_W-1:0] alu_hold_r, alu_hold_nxt, load_hold_r, load_hold_nxt;
  logic              stall_r, stall_nxt;
  logic [DATA_W-1:0] rr_r, rr_nxt, rm_r, rm_nxt, wr_r, wr_nxt, wm_r, wm_nxt;

  logic [CACHE_LINES-1:0] valid_r, valid_nxt;
  logic [BW-1:0]          tag_r [CACHE_LINES];
  logic [BW-1:0]          tag_nxt [CACHE_LINES];

  logic              out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]  out_data_r, out_data_nxt;

  logic [DATA_W-1:0] dmem [MEM_WORDS];
  logic              dm_we;
  logic [WW-1:0]     dm_waddr, dm_raddr;
  logic [DATA_W-1:0] dm_wdata, dm_rdata_r;

  logic [DATA_W-1:0] cmem [CDEPTH];
  logic              cm_we;
  logic [CI_W-1:0]   cm_waddr, cm_raddr;
  logic [DATA_W-1:0] cm_wdata, cm_rdata_r;

  logic [WW-1:0]     word;
  logic [BW-1:0]     block;
  logic [LW-1:0]     line;
  logic [CI_W-1:0]   cidx;
  logic              hit, is_load, bubble;

  logic [WW-1:0]         fill_addr;
  logic [LINE_OFS_W-1:0] prev_ofs;

  mdc_mod_unit u_addr_split (
    .addr  (alu_in_r),
    .word  (word),
    .block (block),
    .line  (line),
    .cidx  (cidx)
  );

  assign hit     = valid_r[line] && (tag_r[line] == block);
  assign is_load = (op_r == OP_LW) || (op_r == OP_LR);
  assign limit   = lp_r ? lmw_r : sw_r;
  assign bubble  = lp_r || sp_r;

  assign fill_addr = {pword_r[WW-1:LINE_OFS_W], fill_r[LINE_OFS_W-1:0]};
  assign prev_ofs  = fill_r[LINE_OFS_W-1:0] - LINE_OFS_W'(1);

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    lmw_nxt       = lmw_r;
    sw_nxt        = sw_r;
    clr_nxt       = clr_r;
    op_nxt        = op_r;
    fa_nxt        = fa_r;
    fb_nxt        = fb_r;
    fc_nxt        = fc_r;
    alu_in_nxt    = alu_in_r;
    val_nxt       = val_r;
    lp_nxt        = lp_r;
    sp_nxt        = sp_r;
    wait_nxt      = wait_r;
    paddr_nxt     = paddr_r;
    pval_nxt      = pval_r;
    pword_nxt     = pword_r;
    pline_nxt     = pline_r;
    fill_nxt      = fill_r;
    alu_hold_nxt  = alu_hold_r;
    load_hold_nxt = load_hold_r;
    stall_nxt     = stall_r;
    rr_nxt        = rr_r;
    rm_nxt        = rm_r;
    wr_nxt        = wr_r;
    wm_nxt        = wm_r;
    valid_nxt     = valid_r;
    tag_nxt       = tag_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    dm_we         = 1'b0;
    dm_waddr      = word;
    dm_wdata      = val_r;
    dm_raddr      = fill_addr;
    cm_we         = 1'b0;
    cm_waddr      = cidx;
    cm_wdata      = val_r;
    cm_raddr      = cidx;

    if (cfg_wr_en) begin
      case (cfg_index)
        REG_LOAD_MISS_WAIT: lmw_nxt = cfg_wdata;
        REG_STORE_WAIT:     sw_nxt  = cfg_wdata;
        default: ;
      endcase
    end

    case (state_r)
      ST_CLEAR: begin
        dm_we    = 1'b1;
        dm_waddr = clr_r;
        dm_wdata = '0;
        if (clr_r == WW'(MEM_WORDS - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_nxt = clr_r + WW'(1);
        end
      end
      ST_IDLE: begin
        if (in_tvalid) begin
          op_nxt     = in_tdata[6:0];
          fa_nxt     = in_tdata[38:7];
          fb_nxt     = in_tdata[70:39];
          fc_nxt     = in_tdata[102:71];
          alu_in_nxt = in_tdata[134:103];
          val_nxt    = in_tdata[166:135];
          state_nxt  = ST_DEC;
        end
      end
      ST_DEC: begin
        if (lp_r || sp_r) begin
          if (wait_r < limit) begin
            wait_nxt  = wait_r + WAIT_W'(1);
            state_nxt = ST_OUT;
          end else if (lp_r) begin
            fill_nxt  = '0;
            state_nxt = ST_FILL;
          end else begin
            dm_we     = 1'b1;
            dm_waddr  = pword_r;
            dm_wdata  = pval_r;
            sp_nxt    = 1'b0;
            wait_nxt  = '0;
            stall_nxt = 1'b0;
            state_nxt = ST_OUT;
          end
        end else if (is_alu_op(op_r)) begin
          alu_hold_nxt = alu_in_r;
          state_nxt    = ST_OUT;
        end else if (is_load || (op_r == OP_SW) ||
                     ((op_r == OP_SC) && (alu_in_r != '1))) begin
          if (is_load) begin
            rr_nxt = rr_r + DATA_W'(1);
            if (op_r == OP_LR) begin
              alu_hold_nxt = alu_in_r;
            end
            if (hit) begin
              state_nxt = ST_LOOK;
            end else begin
              lp_nxt    = 1'b1;
              paddr_nxt = alu_in_r;
              pword_nxt = word;
              pline_nxt = line;
              rm_nxt    = rm_r + DATA_W'(1);
              stall_nxt = 1'b1;
              state_nxt = ST_OUT;
            end
          end else begin
            wr_nxt = wr_r + DATA_W'(1);
            if (hit) begin
              cm_we = 1'b1;
              dm_we = 1'b1;
            end else begin
              wm_nxt = wm_r + DATA_W'(1);
            end
            sp_nxt    = 1'b1;
            paddr_nxt = alu_in_r;
            pval_nxt  = val_r;
            pword_nxt = word;
            pline_nxt = line;
            stall_nxt = 1'b1;
            state_nxt = ST_OUT;
          end
        end else if (op_r == OP_SC) begin
          alu_hold_nxt = '0;
          state_nxt    = ST_OUT;
        end else begin
          state_nxt = ST_OUT;
        end
      end
      ST_LOOK: begin
        load_hold_nxt = cm_rdata_r;
        state_nxt     = ST_OUT;
      end
      ST_FILL: begin
        if (fill_r != '0) begin
          cm_we    = 1'b1;
          cm_waddr = {pline_r, prev_ofs};
          cm_wdata = dm_rdata_r;
          if (prev_ofs == pword_r[LINE_OFS_W-1:0]) begin
            load_hold_nxt = dm_rdata_r;
          end
        end
        if (fill_r == FC_W'(LINE_WORDS)) begin
          tag_nxt[pline_r]   = pword_r[WW-1:LINE_OFS_W];
          valid_nxt[pline_r] = 1'b1;
          lp_nxt             = 1'b0;
          alu_hold_nxt       = paddr_r;
          wait_nxt           = '0;
          stall_nxt          = 1'b0;
          state_nxt          = ST_OUT;
        end else begin
          fill_nxt = fill_r + FC_W'(1);
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {wm_r, wr_r, rm_r, rr_r, stall_r, load_hold_r, alu_hold_r,
                           bubble ? DATA_W'(0) : fc_r, bubble ? DATA_W'(0) : fb_r,
                           bubble ? DATA_W'(0) : fa_r, bubble ? OP_BUBBLE : op_r};
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      lmw_r       <= LOAD_MISS_WAIT_RST;
      sw_r        <= STORE_WAIT_RST;
      clr_r       <= '0;
      lp_r        <= 1'b0;
      sp_r        <= 1'b0;
      wait_r      <= '0;
      paddr_r     <= '0;
      pval_r      <= '0;
      alu_hold_r  <= '0;
      load_hold_r <= '0;
      stall_r     <= 1'b0;
      rr_r        <= '0;
      rm_r        <= '0;
      wr_r        <= '0;
      wm_r        <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      lmw_r       <= lmw_nxt;
      sw_r        <= sw_nxt;
      clr_r       <= clr_nxt;
      lp_r        <= lp_nxt;
      sp_r        <= sp_nxt;
      wait_r      <= wait_nxt;
      paddr_r     <= paddr_nxt;
      pval_r      <= pval_nxt;
      alu_hold_r  <= alu_hold_nxt;
      load_hold_r <= load_hold_nxt;
      stall_r     <= stall_nxt;
      rr_r        <= rr_nxt;
      rm_r        <= rm_nxt;
      wr_r        <= wr_nxt;
      wm_r        <= wm_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    fa_r       <= fa_nxt;
    fb_r       <= fb_nxt;
    fc_r       <= fc_nxt;
    alu_in_r   <= alu_in_nxt;
    val_r      <= val_nxt;
    pword_r    <= pword_nxt;
    pline_r    <= pline_nxt;
    fill_r     <= fill_nxt;
    tag_r      <= tag_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (dm_we) begin
      dmem[dm_waddr] <= dm_wdata;
    end
    dm_rdata_r <= dmem[dm_raddr];
  end

  always_ff @(posedge clk) begin
    if (cm_we) begin
      cmem[cm_waddr] <= cm_wdata;
    end
    cm_rdata_r <= cmem[cm_raddr];
  end

  `MDC_ASSERT(a_single_pending, !(lp_r && sp_r), "load and store pending together")
  `MDC_ASSERT(a_stall_tracks_pending, stall_r == (lp_r || sp_r), "stall flag out of step")
  `MDC_ASSERT(a_wait_needs_pending, (wait_r == '0) || lp_r || sp_r, "wait count without access")
  `MDC_ASSERT_NEXT(a_accept_decodes, in_tvalid && in_tready, state_r == ST_DEC, "request not decoded")

endmodule

`default_nettype wire
